/* design/pps_pkg.sv */
// Shared types, constants and helpers for the preemptive priority scheduler.
package pps_pkg;

	localparam int MAX_TASKS  = 16;
	localparam int SLOT_BITS  = $clog2(MAX_TASKS);
	localparam int COUNT_BITS = SLOT_BITS + 1;
	localparam int TIME_BITS  = 16;
	localparam int ID_BITS    = 8;
	localparam int PRIO_BITS  = 8;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_TICK = 1'b1;

	typedef struct packed {
		logic                 opcode;
		logic [3:0]           slot;
		logic [ID_BITS-1:0]   task_id;
		logic [15:0]          arrival;
		logic [15:0]          burst;
		logic [PRIO_BITS-1:0] prio;
	} task_beat_t;

	typedef struct packed {
		logic               [15:0] tick_time;
		logic                      idle;
		logic               [3:0]  run_slot;
		logic [ID_BITS-1:0]        run_id;
		logic                      finished;
		logic               [15:0] fin_start;
		logic               [15:0] fin_wait;
		logic               [15:0] fin_done_time;
		logic                      all_done;
	} result_beat_t;

	typedef struct packed {
		logic start;
		logic load_wr;
		logic scan_en;
		logic upd_en;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic empty;
		logic last;
	} sts_t;

	function automatic logic [TIME_BITS-1:0] sat_inc(input logic [TIME_BITS-1:0] v);
		return (v == {TIME_BITS{1'b1}}) ? v : v + TIME_BITS'(1);
	endfunction

endpackage

/* design/preemptive_priority_scheduler_core.sv */
// A load beat passes through the LOAD and FINISH states before its result is registered.
// A tick beat passes through SCAN, UPDATE and FINISH, or SCAN and FINISH with no slot in
// use: one pass over the task table picks the winner and a second pass updates wait,
// start and remain, each visiting one slot per cycle. FINISH holds while the result
// register is occupied and stalled. A new beat is not taken until the last one's result is
// loaded, but is taken while that result waits. Reset clears the clock, the task count and
// the remain, wait, start and started tables.
module preemptive_priority_scheduler_core (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  task_valid,
	output logic                  task_stall,
	input  pps_pkg::task_beat_t   task_data,
	output logic                  res_valid,
	input  logic                  res_stall,
	output pps_pkg::result_beat_t res_data,
	input  logic                  cfg_we,
	input  logic [4:0]            cfg_data
);

	pps_pkg::cmd_t cmd;
	pps_pkg::sts_t sts;

	pps_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.task_valid  (task_valid),
		.task_stall  (task_stall),
		.task_opcode (task_data.opcode),
		.res_valid   (res_valid),
		.res_stall   (res_stall),
		.sts         (sts),
		.cmd         (cmd)
	);

	pps_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.task_data (task_data),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.sts       (sts),
		.res_data  (res_data)
	);

endmodule

/* design/pps_ctrl.sv */
// Sequencing state machine for the scheduler: load, scan, update and result handoff.
module pps_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            task_valid,
	output logic            task_stall,
	input  logic            task_opcode,
	output logic            res_valid,
	input  logic            res_stall,
	input  pps_pkg::sts_t   sts,
	output pps_pkg::cmd_t   cmd
);

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_LOAD   = 5'b00010,
		ST_SCAN   = 5'b00100,
		ST_UPDATE = 5'b01000,
		ST_FINISH = 5'b10000
	} state_t;

	state_t state_q, state_d;
	logic   res_valid_q;
	logic   out_free;
	logic   accept;

	assign task_stall = (state_q != ST_IDLE);
	assign accept     = task_valid && !task_stall;
	assign out_free   = !res_valid_q || !res_stall;
	assign res_valid  = res_valid_q;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					cmd.start = 1'b1;
					state_d   = (task_opcode == pps_pkg::OP_TICK) ? ST_SCAN : ST_LOAD;
				end
			end
			ST_LOAD: begin
				cmd.load_wr = 1'b1;
				state_d     = ST_FINISH;
			end
			ST_SCAN: begin
				if (sts.empty) begin
					state_d = ST_FINISH;
				end else begin
					cmd.scan_en = 1'b1;
					if (sts.last) state_d = ST_UPDATE;
				end
			end
			ST_UPDATE: begin
				cmd.upd_en = 1'b1;
				if (sts.last) state_d = ST_FINISH;
			end
			ST_FINISH: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) res_valid_q <= 1'b1;
			else if (!res_stall) res_valid_q <= 1'b0;
		end
	end

`ifndef SYNTHESIS
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!res_valid_q || !res_stall))
		else $error("result register loaded while occupied");
	a_finish_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FINISH && !out_free) |=> (state_q == ST_FINISH))
		else $error("finish left while result register busy");
	a_scan_to_upd: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN && !sts.empty && sts.last) |=> (state_q == ST_UPDATE))
		else $error("scan did not hand over to update");
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q != ST_IDLE))
		else $error("accepted beat did not start work");
`endif

endmodule

/* design/pps_dp.sv */
// Task table, scan comparator, statistics update and result register.
module pps_dp (
	input  logic                    clk,
	input  logic                    arst_n,
	input  pps_pkg::task_beat_t     task_data,
	input  logic                    cfg_we,
	input  logic [4:0]              cfg_data,
	input  pps_pkg::cmd_t           cmd,
	output pps_pkg::sts_t           sts,
	output pps_pkg::result_beat_t   res_data
);

	localparam int TB = pps_pkg::TIME_BITS;
	localparam int SB = pps_pkg::SLOT_BITS;
	localparam int CB = pps_pkg::COUNT_BITS;
	localparam int MT = pps_pkg::MAX_TASKS;

	pps_pkg::task_beat_t   item_q;
	pps_pkg::result_beat_t res_q;

	logic [4:0]    cnt_q;
	logic [CB-1:0] n_used;
	logic [TB-1:0] clock_q;

	logic [TB-1:0]                remain_q  [MT];
	logic [TB-1:0]                wait_q    [MT];
	logic [TB-1:0]                start_q   [MT];
	logic [MT-1:0]                started_q;
	logic [TB-1:0]                arrive_q  [MT];
	logic [pps_pkg::PRIO_BITS-1:0] prio_q   [MT];
	logic [pps_pkg::ID_BITS-1:0]   id_q     [MT];

	logic [SB-1:0] idx_q;
	logic          found_q;
	logic [SB-1:0] best_q;
	logic [pps_pkg::PRIO_BITS-1:0] best_prio_q;
	logic [TB-1:0] best_arr_q;
	logic          alldone_q;
	logic [SB-1:0] run_slot_q;
	logic [pps_pkg::ID_BITS-1:0] run_id_q;
	logic          fin_q;
	logic [TB-1:0] fin_start_q;
	logic [TB-1:0] fin_wait_q;
	logic [TB-1:0] fin_done_q;

	logic [TB-1:0] rd_remain, rd_arr, rd_wait, rd_start, remain_dec;
	logic [pps_pkg::PRIO_BITS-1:0] rd_prio;
	logic          rd_started, ready, better, is_best;
	logic [TB-1:0] ld_arr, ld_burst;

	assign n_used = (cnt_q > 5'(MT)) ? CB'(MT) : CB'(cnt_q);
	assign sts.empty = (n_used == '0);
	assign sts.last  = ((CB'(idx_q) + CB'(1)) == n_used);

	assign rd_remain  = remain_q[idx_q];
	assign rd_arr     = arrive_q[idx_q];
	assign rd_prio    = prio_q[idx_q];
	assign rd_wait    = wait_q[idx_q];
	assign rd_start   = start_q[idx_q];
	assign rd_started = started_q[idx_q];
	assign remain_dec = rd_remain - TB'(1);

	assign ready   = (rd_remain != '0) && (rd_arr <= clock_q);
	assign better  = !found_q || (rd_prio > best_prio_q) ||
		((rd_prio == best_prio_q) && (rd_arr < best_arr_q));
	assign is_best = found_q && (idx_q == best_q);

	assign ld_arr   = TB'(item_q.arrival);
	assign ld_burst = TB'(item_q.burst);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			clock_q   <= '0;
			started_q <= '0;
			for (int i = 0; i < MT; i++) begin
				remain_q[i] <= '0;
				wait_q[i]   <= '0;
				start_q[i]  <= '0;
			end
		end else begin
			if (cfg_we) cnt_q <= cfg_data;
			if (cmd.load_wr) begin
				remain_q[item_q.slot[SB-1:0]]  <= ld_burst;
				wait_q[item_q.slot[SB-1:0]]    <= '0;
				start_q[item_q.slot[SB-1:0]]   <= '0;
				started_q[item_q.slot[SB-1:0]] <= 1'b0;
				clock_q                        <= '0;
			end
			if (cmd.upd_en) begin
				if (is_best) begin
					remain_q[idx_q] <= remain_dec;
					if (!rd_started) begin
						started_q[idx_q] <= 1'b1;
						start_q[idx_q]   <= clock_q;
					end
				end else if (found_q && ready) begin
					wait_q[idx_q] <= pps_pkg::sat_inc(rd_wait);
				end
			end
			if (cmd.out_load && item_q.opcode == pps_pkg::OP_TICK) begin
				clock_q <= pps_pkg::sat_inc(clock_q);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			item_q      <= task_data;
			idx_q       <= '0;
			found_q     <= 1'b0;
			alldone_q   <= 1'b1;
			run_slot_q  <= '0;
			run_id_q    <= '0;
			fin_q       <= 1'b0;
			fin_start_q <= '0;
			fin_wait_q  <= '0;
			fin_done_q  <= '0;
		end
		if (cmd.load_wr) begin
			arrive_q[item_q.slot[SB-1:0]] <= ld_arr;
			prio_q[item_q.slot[SB-1:0]]   <= item_q.prio;
			id_q[item_q.slot[SB-1:0]]     <= item_q.task_id;
		end
		if (cmd.scan_en) begin
			idx_q <= sts.last ? '0 : idx_q + SB'(1);
			if (ready && better) begin
				found_q     <= 1'b1;
				best_q      <= idx_q;
				best_prio_q <= rd_prio;
				best_arr_q  <= rd_arr;
			end
		end
		if (cmd.upd_en) begin
			idx_q <= idx_q + SB'(1);
			if (is_best) begin
				run_slot_q <= idx_q;
				run_id_q   <= id_q[idx_q];
				if (remain_dec == '0) begin
					fin_q       <= 1'b1;
					fin_start_q <= rd_started ? rd_start : clock_q;
					fin_wait_q  <= rd_wait;
					fin_done_q  <= pps_pkg::sat_inc(clock_q);
				end else begin
					alldone_q <= 1'b0;
				end
			end else if (rd_remain != '0) begin
				alldone_q <= 1'b0;
			end
		end
		if (cmd.out_load) begin
			if (item_q.opcode == pps_pkg::OP_TICK) begin
				res_q.tick_time     <= 16'(clock_q);
				res_q.idle          <= !found_q;
				res_q.run_slot      <= 4'(run_slot_q);
				res_q.run_id        <= run_id_q;
				res_q.finished      <= fin_q;
				res_q.fin_start     <= 16'(fin_start_q);
				res_q.fin_wait      <= 16'(fin_wait_q);
				res_q.fin_done_time <= 16'(fin_done_q);
				res_q.all_done      <= alldone_q;
			end else begin
				res_q <= '0;
			end
		end
	end

	assign res_data = res_q;

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 100ps

// Self-checking testbench for the preemptive priority scheduler core.
module tb;

	typedef enum logic [1:0] {ROW_CFG, ROW_BEAT} row_kind_t;

	localparam int DUE_DEPTH = 64;

	typedef struct {
		row_kind_t             kind;
		logic [4:0]            count;
		pps_pkg::task_beat_t   beat;
		bit                    typed;
		pps_pkg::result_beat_t want;
	} plan_row_t;

	logic                  clk;
	logic                  arst_n;
	logic                  task_valid;
	logic                  task_stall;
	pps_pkg::task_beat_t   task_data;
	logic                  res_valid;
	logic                  res_stall;
	pps_pkg::result_beat_t res_data;
	logic                  cfg_we;
	logic [4:0]            cfg_data;

	preemptive_priority_scheduler_core uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.task_valid (task_valid),
		.task_stall (task_stall),
		.task_data  (task_data),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.res_data   (res_data),
		.cfg_we     (cfg_we),
		.cfg_data   (cfg_data)
	);

	logic [4:0]  sched_count;
	logic [15:0] sched_clock;
	logic [15:0] slot_arrival [pps_pkg::MAX_TASKS];
	logic [15:0] slot_left [pps_pkg::MAX_TASKS];
	logic [15:0] slot_wait [pps_pkg::MAX_TASKS];
	logic [15:0] slot_start [pps_pkg::MAX_TASKS];
	logic [7:0]  slot_prio [pps_pkg::MAX_TASKS];
	logic [7:0]  slot_id [pps_pkg::MAX_TASKS];
	bit          slot_began [pps_pkg::MAX_TASKS];

	pps_pkg::result_beat_t due_ring [DUE_DEPTH];
	int                    due_wr;
	int                    due_rd = 0;
	plan_row_t             plan [30];

	int  mismatch_count = 0;
	int  gap_pct;
	int  stall_pct;
	int  hold_asks = 0;
	int  beat_total;
	int  load_total;
	int  tick_total;
	int  idle_total;
	int  finish_total;
	int  random_beats;
	bit  latest_all_done;

	function automatic logic [15:0] bump16(input logic [15:0] v);
		return (v == 16'hFFFF) ? v : v + 16'd1;
	endfunction

	function automatic pps_pkg::result_beat_t schedule_beat(input pps_pkg::task_beat_t b);
		pps_pkg::result_beat_t r;
		int                    n;
		int                    i;
		int                    best;
		bit                    found;
		logic [15:0]           t;
		r = '0;
		found = 1'b0;
		best = 0;
		t = sched_clock;
		n = (sched_count > 5'd16) ? pps_pkg::MAX_TASKS : int'(sched_count);
		if (b.opcode == pps_pkg::OP_LOAD) begin
			slot_id[b.slot] = b.task_id;
			slot_arrival[b.slot] = b.arrival;
			slot_left[b.slot] = b.burst;
			slot_prio[b.slot] = b.prio;
			slot_wait[b.slot] = '0;
			slot_start[b.slot] = '0;
			slot_began[b.slot] = 1'b0;
			sched_clock = '0;
			return r;
		end
		for (i = 0; i < n; i++) begin
			if (slot_left[i] != 0 && slot_arrival[i] <= t) begin
				if (!found || slot_prio[i] > slot_prio[best] ||
				    (slot_prio[i] == slot_prio[best] &&
				     slot_arrival[i] < slot_arrival[best])) begin
					best = i;
					found = 1'b1;
				end
			end
		end
		sched_clock = bump16(t);
		r.tick_time = t;
		if (!found) begin
			r.idle = 1'b1;
		end else begin
			for (i = 0; i < n; i++) begin
				if (i != best && slot_left[i] != 0 && slot_arrival[i] <= t)
					slot_wait[i] = bump16(slot_wait[i]);
			end
			if (!slot_began[best]) begin
				slot_began[best] = 1'b1;
				slot_start[best] = t;
			end
			slot_left[best] = slot_left[best] - 16'd1;
			r.run_slot = 4'(best);
			r.run_id = slot_id[best];
			if (slot_left[best] == 0) begin
				r.finished = 1'b1;
				r.fin_start = slot_start[best];
				r.fin_wait = slot_wait[best];
				r.fin_done_time = sched_clock;
			end
		end
		r.all_done = 1'b1;
		for (i = 0; i < n; i++) begin
			if (slot_left[i] != 0)
				r.all_done = 1'b0;
		end
		return r;
	endfunction

	function automatic plan_row_t cfg_row(input logic [4:0] v);
		plan_row_t p;
		p = '{ROW_CFG, v, '0, 1'b0, '0};
		return p;
	endfunction

	function automatic plan_row_t load_row(input logic [3:0] s, input logic [7:0] id,
	                                       input logic [15:0] arr, input logic [15:0] bu,
	                                       input logic [7:0] pr);
		plan_row_t p;
		p = '{ROW_BEAT, 5'd0, '0, 1'b1, '0};
		p.beat.opcode = pps_pkg::OP_LOAD;
		p.beat.slot = s;
		p.beat.task_id = id;
		p.beat.arrival = arr;
		p.beat.burst = bu;
		p.beat.prio = pr;
		return p;
	endfunction

	function automatic plan_row_t tick_row();
		plan_row_t p;
		p = '{ROW_BEAT, 5'd0, '0, 1'b0, '0};
		p.beat.opcode = pps_pkg::OP_TICK;
		return p;
	endfunction

	function automatic plan_row_t tick_want(input logic [15:0] t, input logic idl,
	                                        input logic [3:0] rs, input logic [7:0] rid,
	                                        input logic fin, input logic [15:0] fs,
	                                        input logic [15:0] fw, input logic [15:0] fd,
	                                        input logic ad);
		plan_row_t p;
		p = tick_row();
		p.typed = 1'b1;
		p.want = '{t, idl, rs, rid, fin, fs, fw, fd, ad};
		return p;
	endfunction

	function automatic pps_pkg::task_beat_t random_beat();
		pps_pkg::task_beat_t b;
		b.opcode = 1'($urandom_range(1));
		b.slot = 4'($urandom_range(15));
		b.task_id = 8'($urandom_range(255));
		b.arrival = 16'($urandom_range(65535));
		b.burst = 16'($urandom_range(65535));
		b.prio = 8'($urandom_range(255));
		return b;
	endfunction

	task automatic check_field(input string name, input logic [15:0] want,
	                           input logic [15:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %h, got %h", $time, name, want, got);
			mismatch_count++;
		end
	endtask

	task automatic check_result(input pps_pkg::result_beat_t got);
		pps_pkg::result_beat_t want;
		if (due_rd == due_wr) begin
			$display("%0t: result beat %h arrived with nothing expected", $time, got);
			mismatch_count++;
			return;
		end
		want = due_ring[due_rd % DUE_DEPTH];
		due_rd++;
		check_field("tick_time", want.tick_time, got.tick_time);
		check_field("idle", 16'(want.idle), 16'(got.idle));
		check_field("run_slot", 16'(want.run_slot), 16'(got.run_slot));
		check_field("run_id", 16'(want.run_id), 16'(got.run_id));
		check_field("finished", 16'(want.finished), 16'(got.finished));
		check_field("fin_start", want.fin_start, got.fin_start);
		check_field("fin_wait", want.fin_wait, got.fin_wait);
		check_field("fin_done_time", want.fin_done_time, got.fin_done_time);
		check_field("all_done", 16'(want.all_done), 16'(got.all_done));
	endtask

	task automatic offer_beat(input pps_pkg::task_beat_t b, input bit typed,
	                          input pps_pkg::result_beat_t want);
		pps_pkg::result_beat_t pred;
		if ($urandom_range(99) < gap_pct) begin
			task_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		task_valid <= 1'b1;
		task_data <= b;
		do @(posedge clk); while (task_stall);
		pred = schedule_beat(b);
		due_ring[due_wr % DUE_DEPTH] = typed ? want : pred;
		due_wr++;
		latest_all_done = pred.all_done;
		beat_total++;
		if (b.opcode == pps_pkg::OP_LOAD) begin
			load_total++;
		end else begin
			tick_total++;
			idle_total += pred.idle;
			finish_total += pred.finished;
		end
	endtask

	task automatic offer_tick();
		pps_pkg::task_beat_t b;
		b = random_beat();
		b.opcode = pps_pkg::OP_TICK;
		offer_beat(b, 1'b0, '0);
	endtask

	task automatic offer_random_load(input int eff);
		pps_pkg::task_beat_t b;
		int                  pick;
		b = random_beat();
		b.opcode = pps_pkg::OP_LOAD;
		if (eff > 0 && $urandom_range(99) < 85)
			b.slot = 4'($urandom_range(eff - 1));
		if ($urandom_range(7) != 0)
			b.arrival = 16'($urandom_range(10));
		pick = $urandom_range(11);
		if (pick == 1)
			b.burst = '0;
		else if (pick > 1)
			b.burst = 16'($urandom_range(1, 6));
		if ($urandom_range(1) == 0)
			b.prio = 8'(100 * $urandom_range(2));
		offer_beat(b, 1'b0, '0);
	endtask

	task automatic wait_drained();
		while (due_wr != due_rd) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_count(input logic [4:0] v);
		task_valid <= 1'b0;
		wait_drained();
		cfg_we <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		sched_count = v;
	endtask

	task automatic run_scenario(input bit squeeze);
		logic [4:0] cnt;
		int         pick;
		int         eff;
		int         start_beats;
		int         ticks;
		pick = $urandom_range(99);
		if (pick < 6)
			cnt = 5'd0;
		else if (pick < 14)
			cnt = 5'd16;
		else if (pick < 19)
			cnt = 5'($urandom_range(17, 31));
		else
			cnt = 5'($urandom_range(1, 6));
		write_count(cnt);
		if (squeeze)
			hold_asks++;
		start_beats = beat_total;
		eff = (cnt > 5'd16) ? pps_pkg::MAX_TASKS : int'(cnt);
		repeat ($urandom_range(1, 6)) offer_random_load(eff);
		for (ticks = 0; ticks < 48; ticks++) begin
			if ($urandom_range(15) == 0)
				offer_random_load(eff);
			else
				offer_tick();
			if (latest_all_done && $urandom_range(3) == 0)
				break;
		end
		random_beats += beat_total - start_beats;
	endtask

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("Mismatches found");
		$finish;
	end

	initial begin
		int hold_left;
		int hold_seen;
		hold_left = 0;
		hold_seen = 0;
		res_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && res_valid && !res_stall)
				check_result(res_data);
			if (hold_asks != hold_seen) begin
				hold_seen = hold_asks;
				hold_left = 700;
			end
			if (hold_left > 0) begin
				hold_left--;
				res_stall <= 1'b1;
			end else begin
				res_stall <= ($urandom_range(99) < stall_pct);
			end
		end
	end

	initial begin
		int p;
		int phase_start;
		int gap_set [4];
		int stall_set [4];
		arst_n <= 1'b0;
		task_valid <= 1'b0;
		task_data <= '0;
		cfg_we <= 1'b0;
		cfg_data <= '0;
		gap_set = '{0, 57, 0, 37};
		stall_set = '{0, 0, 57, 37};
		gap_pct = 0;
		stall_pct = 0;
		due_wr = 0;
		beat_total = 0;
		load_total = 0;
		tick_total = 0;
		idle_total = 0;
		finish_total = 0;
		random_beats = 0;
		latest_all_done = 1'b0;
		sched_count = '0;
		sched_clock = '0;
		for (p = 0; p < pps_pkg::MAX_TASKS; p++) begin
			slot_arrival[p] = '0;
			slot_left[p] = '0;
			slot_wait[p] = '0;
			slot_start[p] = '0;
			slot_prio[p] = '0;
			slot_id[p] = '0;
			slot_began[p] = 1'b0;
		end

		plan = '{
			tick_want(16'd0, 1'b1, 4'd0, 8'h00, 1'b0, 16'd0, 16'd0, 16'd0, 1'b1),
			cfg_row(5'd16),
			tick_want(16'd1, 1'b1, 4'd0, 8'h00, 1'b0, 16'd0, 16'd0, 16'd0, 1'b1),
			load_row(4'd15, 8'hFF, 16'h0000, 16'hFFFF, 8'hFF),
			load_row(4'd0, 8'h00, 16'h0000, 16'd1, 8'hFF),
			tick_want(16'd0, 1'b0, 4'd0, 8'h00, 1'b1, 16'd0, 16'd0, 16'd1, 1'b0),
			tick_row(),
			load_row(4'd3, 8'h5A, 16'd2, 16'd2, 8'hFF),
			tick_row(),
			tick_row(),
			tick_row(),
			load_row(4'd15, 8'hC3, 16'hFFFF, 16'd4, 8'h00),
			tick_want(16'd0, 1'b1, 4'd0, 8'h00, 1'b0, 16'd0, 16'd0, 16'd0, 1'b0),
			tick_want(16'd1, 1'b1, 4'd0, 8'h00, 1'b0, 16'd0, 16'd0, 16'd0, 1'b0),
			tick_row(),
			load_row(4'd1, 8'h11, 16'd0, 16'd2, 8'h01),
			tick_row(),
			tick_row(),
			tick_row(),
			load_row(4'd2, 8'h22, 16'd0, 16'd0, 8'h80),
			cfg_row(5'd31),
			tick_want(16'd0, 1'b1, 4'd0, 8'h00, 1'b0, 16'd0, 16'd0, 16'd0, 1'b0),
			cfg_row(5'd1),
			tick_want(16'd1, 1'b1, 4'd0, 8'h00, 1'b0, 16'd0, 16'd0, 16'd0, 1'b1),
			cfg_row(5'd0),
			tick_want(16'd2, 1'b1, 4'd0, 8'h00, 1'b0, 16'd0, 16'd0, 16'd0, 1'b1),
			cfg_row(5'd3),
			load_row(4'd0, 8'hA0, 16'h0000, 16'hFFFF, 8'd200),
			load_row(4'd1, 8'hB1, 16'h0000, 16'd1, 8'd10),
			load_row(4'd2, 8'hC2, 16'hFFFF, 16'd3, 8'd20)
		};

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			if (plan[i].kind == ROW_CFG)
				write_count(plan[i].count);
			else
				offer_beat(plan[i].beat, plan[i].typed, plan[i].want);
		end

		// The last three loads leave a long high-priority task running ahead of
		// one waiting task and one that has not arrived yet.
		repeat (8) offer_tick();

		for (p = 0; p < 4; p++) begin
			gap_pct = gap_set[p];
			stall_pct = stall_set[p];
			phase_start = random_beats;
			run_scenario(p == 0);
			while (random_beats - phase_start < 165)
				run_scenario(1'b0);
		end

		task_valid <= 1'b0;
		wait_drained();
		$display("Sent %0d beats: %0d loads and %0d ticks, %0d idle ticks, %0d task completions.",
		         beat_total, load_total, tick_total, idle_total, finish_total);
		$display("Traffic ran under four idle and stall profiles with one long output hold-off.");
		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

/* files.f */
design/pps_pkg.sv
design/pps_ctrl.sv
design/pps_dp.sv
design/preemptive_priority_scheduler_core.sv
tb/sv/tb.sv
